FILE: hdl/sdes_encrypt_block_defines.svh
// Assertion macros for the S-DES encrypt block.
// Standalone; included by modules that carry concurrent checks.
`ifndef SDES_ENCRYPT_BLOCK_DEFINES_SVH
`define SDES_ENCRYPT_BLOCK_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on each rising clock edge, skipped while reset is low.
`define SDES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on each rising clock edge, reset included.
`define SDES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDES_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDES_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/sdes_pkg.sv
// Shared types, permutation tables and round function for the S-DES block.
// No dependencies.
package sdes_pkg;

    typedef logic [2:0] tab8_idx_t [8];
    typedef logic [1:0] tab4_idx_t [4];
    typedef logic [3:0] tab10_idx_t [10];
    typedef logic [1:0] sbox_t [16];

    // Position 0 of every table is the most significant bit.
    localparam tab8_idx_t  TAB_IP    = '{3'd1, 3'd5, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd6};
    localparam tab8_idx_t  TAB_IPI   = '{3'd3, 3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd7, 3'd5};
    localparam logic [1:0] TAB_EP [8] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0};
    localparam tab4_idx_t  TAB_P4    = '{2'd1, 2'd3, 2'd2, 2'd0};
    localparam tab10_idx_t TAB_P10   = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd0, 4'd8,
                                         4'd7, 4'd5};
    localparam logic [3:0] TAB_P8 [8] = '{4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8};

    localparam sbox_t SBOX0 = '{2'd1, 2'd0, 2'd3, 2'd2,
                                2'd3, 2'd2, 2'd1, 2'd0,
                                2'd0, 2'd2, 2'd1, 2'd3,
                                2'd3, 2'd1, 2'd3, 2'd2};
    localparam sbox_t SBOX1 = '{2'd0, 2'd1, 2'd2, 2'd3,
                                2'd2, 2'd0, 2'd1, 2'd3,
                                2'd3, 2'd0, 2'd1, 2'd0,
                                2'd2, 2'd1, 2'd0, 2'd3};

    // One word moving down the cell row.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } sdes_word_t;

    typedef struct packed {
        logic [7:0] k1;
        logic [7:0] k2;
    } sdes_subkeys_t;

    function automatic logic [7:0] ip(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7 - i] = v[3'(7 - TAB_IP[i])];
        return r;
    endfunction

    function automatic logic [7:0] ip_inv(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7 - i] = v[3'(7 - TAB_IPI[i])];
        return r;
    endfunction

    function automatic logic [7:0] ep(input logic [3:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7 - i] = v[2'(3 - TAB_EP[i])];
        return r;
    endfunction

    function automatic logic [3:0] p4(input logic [3:0] v);
        logic [3:0] r;
        for (int i = 0; i < 4; i++) r[3 - i] = v[2'(3 - TAB_P4[i])];
        return r;
    endfunction

    function automatic logic [9:0] p10(input logic [9:0] v);
        logic [9:0] r;
        for (int i = 0; i < 10; i++) r[9 - i] = v[4'(9 - TAB_P10[i])];
        return r;
    endfunction

    function automatic logic [7:0] p8(input logic [9:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7 - i] = v[4'(9 - TAB_P8[i])];
        return r;
    endfunction

    // Rotate each 5-bit half left by one.
    function automatic logic [9:0] rot_halves(input logic [9:0] k);
        return {k[8:5], k[9], k[3:0], k[4]};
    endfunction

    // One Feistel round: left half takes F(right, subkey), right half passes.
    function automatic logic [7:0] feistel(input logic [7:0] x, input logic [7:0] sk);
        logic [7:0] e;
        logic [3:0] idx0;
        logic [3:0] idx1;
        logic [3:0] sb;
        e    = ep(x[3:0]) ^ sk;
        idx0 = {e[7], e[4], e[6], e[5]};
        idx1 = {e[3], e[0], e[2], e[1]};
        sb   = {SBOX0[idx0], SBOX1[idx1]};
        return {x[7:4] ^ p4(sb), x[3:0]};
    endfunction

endpackage

FILE: hdl/sdes_keysched.sv
// Subkey register for the S-DES block: derives K1 and K2 on each key write.
// Depends on sdes_pkg.
module sdes_keysched (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [9:0]             cfg_wr_data,
    output sdes_pkg::sdes_subkeys_t subkeys
);

    sdes_pkg::sdes_subkeys_t subkeys_reg;
    sdes_pkg::sdes_subkeys_t subkeys_next;
    logic [9:0]              ka;
    logic [9:0]              kb;

    always_comb begin
        ka              = sdes_pkg::rot_halves(sdes_pkg::p10(cfg_wr_data));
        kb              = sdes_pkg::rot_halves(sdes_pkg::rot_halves(ka));
        subkeys_next.k1 = sdes_pkg::p8(ka);
        subkeys_next.k2 = sdes_pkg::p8(kb);
    end

    // Key of zero gives all-zero subkeys, so reset clears them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subkeys_reg <= '0;
        end else if (cfg_wr_en) begin
            subkeys_reg <= subkeys_next;
        end
    end

    assign subkeys = subkeys_reg;

endmodule

FILE: hdl/sdes_round_cell.sv
// One round cell of the S-DES row: a Feistel round into a held word register.
// Depends on sdes_pkg and sdes_encrypt_block_defines.svh.
`include "sdes_encrypt_block_defines.svh"

module sdes_round_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  sdes_pkg::sdes_word_t up_word,
    output logic                up_ready,
    input  logic [7:0]          subkey,
    output sdes_pkg::sdes_word_t down_word,
    input  logic                down_ready
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Take a new word when empty or when the held word leaves this cycle.
    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_word.valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_word.valid) begin
            data_reg <= sdes_pkg::feistel(up_word.data, subkey);
        end
    end

    assign down_word.valid = valid_reg;
    assign down_word.data  = data_reg;

    `SDES_ASSERT(a_hold_on_stall, aclk, aresetn, valid_reg && !down_ready |=> valid_reg && $stable(data_reg), "round cell dropped or changed a stalled word")
    `SDES_ASSERT(a_ready_when_empty, aclk, aresetn, !valid_reg |-> up_ready, "round cell empty but not ready")
    `SDES_ASSERT_ALWAYS(a_empty_after_reset, aclk, !aresetn |=> !valid_reg, "round cell holds a word after reset")

endmodule

FILE: hdl/sdes_encrypt_block.sv
// Top level of the S-DES encrypt block: key schedule and a row of two round cells.
// Depends on sdes_pkg, sdes_keysched and sdes_round_cell.
//
//   port group   dir  payload                              role
//   s_*          in   tdata[7:0] = plaintext               plaintext words
//   m_*          out  tdata[7:0] = ciphertext             ciphertext words
//   cfg_*        in   cfg_wr_data[9:0] = cipher_key        key write, no read-back
//
// Words are registered in round cell 1, then in round cell 2, which drives
// m_tvalid. The row takes one word every cycle while s_tready is high; rate is
// set by the round cells each holding one word. A stall on m_tready holds the
// last cell and backs up the row one cell at a time; s_tready drops only when
// both cells are full and the output stalls. aresetn is synchronous and active
// low; it empties both cells and sets the subkeys to those of an all-zero
// key. A key write takes effect for the word accepted in the next cycle.
module sdes_encrypt_block (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] plaintext
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] ciphertext
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data   // [9:0] cipher_key
);

    sdes_pkg::sdes_subkeys_t subkeys;
    sdes_pkg::sdes_word_t    word_in;
    sdes_pkg::sdes_word_t    word_r1;
    sdes_pkg::sdes_word_t    word_r1_swap;
    sdes_pkg::sdes_word_t    word_r2;
    logic                    ready_r2;

    sdes_keysched u_keysched (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .subkeys     (subkeys)
    );

    // Initial permutation is wiring ahead of the first cell.
    assign word_in.valid = s_tvalid;
    assign word_in.data  = sdes_pkg::ip(s_tdata);

    sdes_round_cell u_round1 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .up_word    (word_in),
        .up_ready   (s_tready),
        .subkey     (subkeys.k1),
        .down_word  (word_r1),
        .down_ready (ready_r2)
    );

    // Swap halves between the two rounds.
    assign word_r1_swap.valid = word_r1.valid;
    assign word_r1_swap.data  = {word_r1.data[3:0], word_r1.data[7:4]};

    sdes_round_cell u_round2 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .up_word    (word_r1_swap),
        .up_ready   (ready_r2),
        .subkey     (subkeys.k2),
        .down_word  (word_r2),
        .down_ready (m_tready)
    );

    // Inverse initial permutation is wiring behind the last cell's register.
    assign m_tvalid = word_r2.valid;
    assign m_tdata  = sdes_pkg::ip_inv(word_r2.data);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for sdes_encrypt_block: plaintext words in, ciphertext words out.
// Stand-alone; needs only the RTL of the block and its package.
module tb_top;

    // S-box contents packed two bits per entry, entry 0 in the lowest bits.
    localparam logic [31:0] S0_ROWS = {2'd2, 2'd3, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd0,
                                       2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1};
    localparam logic [31:0] S1_ROWS = {2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0, 2'd3,
                                       2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};
    localparam int RAND_PHASES = 8;
    localparam int WORDS_PER_PHASE = 50;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;        // [7:0] plaintext
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;             // [7:0] ciphertext
    logic       cfg_wr_en = 1'b0;
    logic [9:0] cfg_wr_data = '0;    // [9:0] cipher_key

    logic [7:0] plain_q[$];          // plaintext words waiting to be sent
    logic [7:0] expected_cipher_q[$]; // ciphertexts owed by the block, oldest first
    logic [9:0] key_now = '0;        // key the block holds right now
    int         mismatch_count = 0;
    int         send_gap = 0;
    int         rx_hold = 0;
    bit         tx_steady = 1'b0;
    bit         rx_steady = 1'b0;

    sdes_encrypt_block DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Cipher predictor. Bit patterns below are the S-DES tables written
    // out as concatenations, first table position = most significant bit.
    // ------------------------------------------------------------------

    // One Feistel round: the left nibble takes F(right, subkey).
    function automatic logic [7:0] sdes_round(input logic [7:0] x, input logic [7:0] sk);
        logic [3:0] r;
        logic [7:0] e;
        logic [3:0] i0;
        logic [3:0] i1;
        logic [3:0] sb;
        logic [3:0] f;
        r  = x[3:0];
        e  = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ sk;   // expand
        i0 = {e[7], e[4], e[6], e[5]};                               // row, column
        i1 = {e[3], e[0], e[2], e[1]};
        sb = {S0_ROWS[{i0, 1'b0} +: 2], S1_ROWS[{i1, 1'b0} +: 2]};
        f  = {sb[2], sb[0], sb[1], sb[3]};                           // P4
        return {x[7:4] ^ f, r};
    endfunction

    function automatic logic [7:0] sdes_encrypt(input logic [7:0] pt, input logic [9:0] key);
        logic [9:0] k;
        logic [7:0] k1;
        logic [7:0] k2;
        logic [7:0] x;
        // P10, rotate each half by one, P8 -> K1
        k  = {key[7], key[5], key[8], key[3], key[6], key[0], key[9], key[1], key[2], key[4]};
        k  = {k[8:5], k[9], k[3:0], k[4]};
        k1 = {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
        // two more rotations, P8 -> K2
        k  = {k[7:5], k[9:8], k[2:0], k[4:3]};
        k2 = {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
        // IP, round K1, swap nibbles, round K2, inverse IP
        x  = {pt[6], pt[2], pt[5], pt[7], pt[4], pt[0], pt[3], pt[1]};
        x  = sdes_round(x, k1);
        x  = {x[3:0], x[7:4]};
        x  = sdes_round(x, k2);
        return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
    endfunction

    // Mostly back-to-back, some short pauses, now and then a long one.
    function automatic int idle_len(input bit steady);
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60)
            return 0;
        if (pick < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Plaintext driver: load the next word once the current one is taken,
    // holding off by a random gap after each handshake.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (plain_q.size() != 0) begin
                s_tdata  <= plain_q.pop_front();
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
                send_gap = idle_len(tx_steady);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ciphertext sink: drop m_tready for random stretches.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            rx_hold = idle_len(rx_steady);
            m_tready <= (rx_hold == 0);
            if (rx_hold > 0)
                rx_hold--;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted plaintext word, check every
    // accepted ciphertext word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [7:0] want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_cipher_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected ciphertext word %02h", m_tdata));
                end else begin
                    want = expected_cipher_q.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("ciphertext %02h, expected %02h (key %03h)",
                                                  m_tdata, want, key_now));
                end
            end
            if (s_tvalid && s_tready)
                expected_cipher_q.push_back(sdes_encrypt(s_tdata, key_now));
        end
    end

    // Write the key while the block is idle; it applies from the next word on.
    task automatic load_key(input logic [9:0] k);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        key_now = k;
    endtask

    // Wait until every word is sent and answered, then let the two-stage row settle.
    task automatic drain_words();
        do
            @(negedge aclk);
        while (plain_q.size() != 0 || s_tvalid || expected_cipher_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic queue_random_words(input int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                plain_q.push_back(8'h00);
            else if (pick == 1)
                plain_q.push_back(8'hFF);
            else
                plain_q.push_back(8'($urandom));
        end
    endtask

    initial begin
        logic [9:0] k;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset key (all zero): extremes and alternating patterns.
        plain_q = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};
        drain_words();

        // All-ones key.
        load_key(10'h3FF);
        plain_q = '{8'h00, 8'hFF, 8'h97};
        drain_words();

        // Textbook key with its textbook plaintext.
        load_key(10'h282);
        plain_q = '{8'h97, 8'h00, 8'hFF};
        drain_words();

        // Explicit write of the zero key.
        load_key(10'h000);
        plain_q = '{8'h97, 8'h5A};
        drain_words();

        // Random phases: fresh key each time, with the extremes now and then.
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       k = 10'h000;
                1:       k = 10'h3FF;
                default: k = 10'($urandom);
            endcase
            load_key(k);
            queue_random_words(WORDS_PER_PHASE);
            drain_words();
        end

        if (mismatch_count == 0)
            $display("** sdes_encrypt_block: PASSED **");
        else
            $display("** sdes_encrypt_block: FAILED **");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("** sdes_encrypt_block: FAILED **");
        $finish;
    end

endmodule

FILE: sdes_encrypt_block.f
+incdir+hdl
hdl/sdes_pkg.sv
hdl/sdes_keysched.sv
hdl/sdes_round_cell.sv
hdl/sdes_encrypt_block.sv
test/tb_top.sv
